FILE: rtl/core/hrci_pkg.sv
// ----------------------------------------------------------------------------
// hrci_pkg: shared types and constants
// Operation codes, configuration register indexes, the configuration bundle
// and the sequencer states of the row/column interchange block.
// ----------------------------------------------------------------------------
`default_nettype none

package hrci_pkg;

  // One stored entry is {imag, real}, 64 bits each
  localparam int unsigned PART_W = 64;
  localparam int unsigned DATA_W = 2 * PART_W;
  localparam int unsigned SIGN_BIT = PART_W - 1;

  localparam int unsigned IDX_W = 6;
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 7;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SWAP  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE  = 2'd0,
    CFG_LOWER = 2'd1,
    CFG_CONJ  = 2'd2,
    CFG_SKEW  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              lower;
    logic              conj;
    logic              skew;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PA,
    S_PB,
    S_WA,
    S_WB
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/hrci_ram.sv
// ----------------------------------------------------------------------------
// hrci_ram: generic single-port RAM
// One read or one write per cycle; read data is registered and holds its
// value across write cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module hrci_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hrci_engine.sv
// ----------------------------------------------------------------------------
// hrci_engine: command sequencer and swap datapath
// Decodes a command, checks indices, and for an interchange walks i over
// 0..n-1, doing one read-read-write-write pair exchange per step through the
// single RAM port.
// ----------------------------------------------------------------------------
`default_nettype none

module hrci_engine
  import hrci_pkg::*;
#(
  parameter int unsigned MAX_ORDER = 64
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    start_i,
  output logic                                         busy_o,
  input  wire logic [1:0]                              op_i,
  input  wire logic [IDX_W-1:0]                        row_index_i,
  input  wire logic [IDX_W-1:0]                        col_index_i,
  input  wire logic [PART_W-1:0]                       real_bits_i,
  input  wire logic [PART_W-1:0]                       imag_bits_i,
  input  wire logic [IDX_W-1:0]                        first_index_i,
  input  wire logic [IDX_W-1:0]                        second_index_i,
  input  wire cfg_t                                    cfg_i,
  output logic                                         ram_en_o,
  output logic                                         ram_we_o,
  output logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0]       ram_addr_o,
  output logic [DATA_W-1:0]                            ram_wdata_o,
  input  wire logic [DATA_W-1:0]                       ram_rdata_i,
  output logic                                         done_o,
  output logic [PART_W-1:0]                            read_real_o,
  output logic [PART_W-1:0]                            read_imag_o,
  output logic                                         status_o
);

  localparam int unsigned IW = $clog2(MAX_ORDER);
  localparam int unsigned AW = $clog2(MAX_ORDER * MAX_ORDER);
  localparam int unsigned NW = $clog2(MAX_ORDER + 1);
  localparam int unsigned SW = (NW > SIZE_W) ? NW : SIZE_W;

  // Entry (r,c) lives at r + c*MAX_ORDER
  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) + AW'(c) * AW'(MAX_ORDER);
  endfunction

  state_e            state_q, state_d;
  logic [NW-1:0]     i_q, i_d;
  logic [NW-1:0]     n_q, n_d;
  logic [IW-1:0]     k_q, k_d;
  logic [IW-1:0]     l_q, l_d;
  logic [DATA_W-1:0] a_q, a_d;
  logic              done_q, done_d;
  logic              status_q, status_d;
  logic [PART_W-1:0] rd_real_q, rd_real_d;
  logic [PART_W-1:0] rd_imag_q, rd_imag_d;

  // Effective order, indices widened for compares
  logic [SW-1:0] size_ext, n_ext, row_ext, col_ext, k_ext, l_ext;
  logic          elem_ok;

  assign size_ext = SW'(cfg_i.size);
  assign n_ext    = (size_ext > SW'(MAX_ORDER)) ? SW'(MAX_ORDER) : size_ext;
  assign row_ext  = SW'(row_index_i);
  assign col_ext  = SW'(col_index_i);
  assign k_ext    = SW'(first_index_i);
  assign l_ext    = SW'(second_index_i);
  assign elem_ok  = (row_ext < n_ext) && (col_ext < n_ext);

  // Sign flip mask for crossed and corner entries
  logic [DATA_W-1:0] flip_mask;
  assign flip_mask = {(cfg_i.conj ^ cfg_i.skew), {(PART_W-1){1'b0}},
                      cfg_i.skew, {(PART_W-1){1'b0}}};

  // Pair of entries for step i, in lower-triangle coordinates
  logic [IW-1:0]     ic, ra, ca, rb, cb;
  logic              flip;
  logic [AW-1:0]     addr_a, addr_b;
  logic [DATA_W-1:0] mask;

  assign ic = i_q[IW-1:0];

  always_comb begin
    priority if (ic < k_q) begin
      ra = k_q; ca = ic;  rb = l_q; cb = ic;  flip = 1'b0;
    end else if (ic == k_q) begin
      ra = l_q; ca = k_q; rb = l_q; cb = k_q; flip = 1'b1;
    end else if (ic < l_q) begin
      ra = ic;  ca = k_q; rb = l_q; cb = ic;  flip = 1'b1;
    end else if (ic == l_q) begin
      ra = k_q; ca = k_q; rb = l_q; cb = l_q; flip = 1'b0;
    end else begin
      ra = ic;  ca = k_q; rb = ic;  cb = l_q; flip = 1'b0;
    end
  end

  // Upper triangle is the transpose of the same walk
  assign addr_a = cfg_i.lower ? addr_of(ra, ca) : addr_of(ca, ra);
  assign addr_b = cfg_i.lower ? addr_of(rb, cb) : addr_of(cb, rb);
  assign mask   = flip ? flip_mask : '0;

  // Next state and RAM control
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    n_d         = n_q;
    k_d         = k_q;
    l_d         = l_q;
    a_d         = a_q;
    done_d      = 1'b0;
    status_d    = status_q;
    rd_real_d   = '0;
    rd_imag_d   = '0;
    ram_en_o    = 1'b0;
    ram_we_o    = 1'b0;
    ram_addr_o  = addr_a;
    ram_wdata_o = {imag_bits_i, real_bits_i};

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ram_addr_o = addr_of(row_ext[IW-1:0], col_ext[IW-1:0]);
          unique case (op_e'(op_i))
            OP_WRITE: begin
              done_d   = 1'b1;
              status_d = !elem_ok;
              ram_en_o = elem_ok;
              ram_we_o = 1'b1;
            end
            OP_READ: begin
              if (elem_ok) begin
                ram_en_o = 1'b1;
                state_d  = S_READ;
              end else begin
                done_d   = 1'b1;
                status_d = 1'b1;
              end
            end
            OP_SWAP: begin
              if ((n_ext == '0) || (k_ext == l_ext)) begin
                done_d   = 1'b1;
                status_d = 1'b0;
              end else if ((k_ext > l_ext) || (l_ext >= n_ext)) begin
                done_d   = 1'b1;
                status_d = 1'b1;
              end else begin
                k_d     = k_ext[IW-1:0];
                l_d     = l_ext[IW-1:0];
                n_d     = n_ext[NW-1:0];
                i_d     = '0;
                state_d = S_PA;
              end
            end
            OP_NONE: begin
              done_d   = 1'b1;
              status_d = 1'b1;
            end
            default: begin
              done_d   = 1'b1;
              status_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        done_d    = 1'b1;
        status_d  = 1'b0;
        rd_real_d = ram_rdata_i[PART_W-1:0];
        rd_imag_d = ram_rdata_i[DATA_W-1:PART_W];
        state_d   = S_IDLE;
      end
      // read first entry of the pair
      S_PA: begin
        ram_en_o = 1'b1;
        state_d  = S_PB;
      end
      // read second entry, capture first
      S_PB: begin
        ram_en_o   = 1'b1;
        ram_addr_o = addr_b;
        a_d        = ram_rdata_i;
        state_d    = S_WA;
      end
      // first <- f(second); read data still holds second
      S_WA: begin
        ram_en_o    = 1'b1;
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i ^ mask;
        state_d     = S_WB;
      end
      // second <- f(first), then next step or finish
      S_WB: begin
        ram_en_o    = 1'b1;
        ram_we_o    = 1'b1;
        ram_addr_o  = addr_b;
        ram_wdata_o = a_q ^ mask;
        if (i_q == n_q - NW'(1)) begin
          done_d   = 1'b1;
          status_d = 1'b0;
          state_d  = S_IDLE;
        end else begin
          i_d     = i_q + NW'(1);
          state_d = S_PA;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    n_q       <= n_d;
    k_q       <= k_d;
    l_q       <= l_d;
    a_q       <= a_d;
    status_q  <= status_d;
    rd_real_q <= rd_real_d;
    rd_imag_q <= rd_imag_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign read_real_o = rd_real_q;
  assign read_imag_o = rd_imag_q;

endmodule

`default_nettype wire

FILE: rtl/core/hermitian_row_col_interchange.sv
// ----------------------------------------------------------------------------
// hermitian_row_col_interchange: row/column interchange on a stored triangle
// Holds the configuration registers and ties the command sequencer to the
// single-port entry RAM.
// ----------------------------------------------------------------------------
// Sequence: write, rejected or no-op commands complete from idle; a read adds
//   S_READ; an interchange runs n pairs, one RAM port, four accesses per entry pair.
// Throughput: a new command is taken the cycle busy is low again; results
//   come one per command as a one-cycle done_o strobe, never stalled.
// Reset: sequencer and configuration clear; RAM contents are undefined
//   until written, no clearing pass.
`default_nettype none

module hermitian_row_col_interchange
  import hrci_pkg::*;
#(
  parameter int unsigned MAX_ORDER = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // command transaction
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            op_i,
  input  wire logic [IDX_W-1:0]      row_index_i,
  input  wire logic [IDX_W-1:0]      col_index_i,
  input  wire logic [PART_W-1:0]     real_bits_i,
  input  wire logic [PART_W-1:0]     imag_bits_i,
  input  wire logic [IDX_W-1:0]      first_index_i,
  input  wire logic [IDX_W-1:0]      second_index_i,
  // result
  output logic                       done_o,
  output logic [PART_W-1:0]          read_real_o,
  output logic [PART_W-1:0]          read_imag_o,
  output logic                       status_o,
  // configuration write
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int unsigned AW    = $clog2(DEPTH);

  cfg_t cfg_q, cfg_d;

  // Configuration registers, written whenever the block is idle
  assign cfg_ready_o = !busy;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SIZE:  cfg_d.size  = cfg_data_i[SIZE_W-1:0];
        CFG_LOWER: cfg_d.lower = cfg_data_i[0];
        CFG_CONJ:  cfg_d.conj  = cfg_data_i[0];
        CFG_SKEW:  cfg_d.skew  = cfg_data_i[0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Sequencer to RAM
  logic              ram_en, ram_we;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  hrci_engine #(
    .MAX_ORDER(MAX_ORDER)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .op_i           (op_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .real_bits_i    (real_bits_i),
    .imag_bits_i    (imag_bits_i),
    .first_index_i  (first_index_i),
    .second_index_i (second_index_i),
    .cfg_i          (cfg_q),
    .ram_en_o       (ram_en),
    .ram_we_o       (ram_we),
    .ram_addr_o     (ram_addr),
    .ram_wdata_o    (ram_wdata),
    .ram_rdata_i    (ram_rdata),
    .done_o         (done_o),
    .read_real_o    (read_real_o),
    .read_imag_o    (read_imag_o),
    .status_o       (status_o)
  );

  hrci_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
